/* design/mct_pkg.sv */
// Package for the MIPS constant tracker: decoded operation kinds, the
// operation word passed from the front end to the back end, and opcode
// constants. No dependencies.
package mct_pkg;

  localparam int unsigned NumRegs = 32;
  localparam int unsigned RegW    = 5;
  localparam int unsigned DataW   = 32;

  localparam logic [RegW-1:0] GpReg = 5'd28;

  // Primary opcodes
  localparam logic [5:0] OpSpecial = 6'h00;
  localparam logic [5:0] OpAddi    = 6'h08;
  localparam logic [5:0] OpAddiu   = 6'h09;
  localparam logic [5:0] OpOri     = 6'h0D;
  localparam logic [5:0] OpImmLast = 6'h0E;
  localparam logic [5:0] OpLui     = 6'h0F;

  // R-type function codes
  localparam logic [5:0] FnJr   = 6'h08;
  localparam logic [5:0] FnJalr = 6'h09;
  localparam logic [5:0] FnAddu = 6'h21;

  // Instruction class codes
  localparam logic [2:0] ClsLoad  = 3'd1;
  localparam logic [2:0] ClsStore = 3'd2;
  localparam logic [2:0] ClsCall  = 3'd3;

  // Known pattern after restart: register zero and the global pointer
  localparam logic [NumRegs-1:0] RestartKnown = 32'h1000_0001;
  // Registers lost across a call: 1-15, 24, 25 and 31
  localparam logic [NumRegs-1:0] CallClobber  = 32'h8300_FFFE;

  typedef enum logic [3:0] {
    KindNop,
    KindRestart,
    KindLui,
    KindAddi,
    KindOri,
    KindLoad,
    KindStore,
    KindRtype,
    KindCall,
    KindForgetRt
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [RegW-1:0]   rs;
    logic [RegW-1:0]   rt;
    logic [RegW-1:0]   rd;
    logic [DataW-1:0]  imm;      // already extended as the kind needs
    logic              is_addu;
    logic              keep_rd;  // jr / jalr leave rd alone
  } op_t;

endpackage

/* design/mct_ram.sv */
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module mct_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

/* design/mct_front.sv */
// Front end of the MIPS constant tracker: unpacks the input item and
// classifies it into an operation word. Depends on mct_pkg.
module mct_front (
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [47:0]   s_axis_tdata_i,
  input  logic          s_axis_tuser_i,
  input  logic          q_full_i,
  output logic          q_push_o,
  output mct_pkg::op_t  q_op_o
);

  logic [5:0]  opcode;
  logic [4:0]  src_reg;
  logic [4:0]  tgt_reg;
  logic [4:0]  dst_reg;
  logic [5:0]  func_code;
  logic [15:0] immediate;
  logic [2:0]  insn_class;

  assign opcode     = s_axis_tdata_i[5:0];
  assign src_reg    = s_axis_tdata_i[10:6];
  assign tgt_reg    = s_axis_tdata_i[15:11];
  assign dst_reg    = s_axis_tdata_i[20:16];
  assign func_code  = s_axis_tdata_i[26:21];
  assign immediate  = s_axis_tdata_i[42:27];
  assign insn_class = s_axis_tdata_i[45:43];

  assign s_axis_tready_o = !q_full_i;
  assign q_push_o        = s_axis_tvalid_i && !q_full_i;

  always_comb begin
    q_op_o.rs      = src_reg;
    q_op_o.rt      = tgt_reg;
    q_op_o.rd      = dst_reg;
    q_op_o.is_addu = (func_code == mct_pkg::FnAddu);
    q_op_o.keep_rd = (func_code == mct_pkg::FnJr) || (func_code == mct_pkg::FnJalr);
    q_op_o.imm     = {{16{immediate[15]}}, immediate};
    q_op_o.kind    = mct_pkg::KindNop;
    // Priority follows the tracking rules: restart, lui, immediate ALU, memory,
    // special, call, remaining immediate opcodes.
    if (s_axis_tuser_i) begin
      q_op_o.kind = mct_pkg::KindRestart;
    end else if (opcode == mct_pkg::OpLui) begin
      q_op_o.kind = mct_pkg::KindLui;
      q_op_o.imm  = {immediate, 16'h0000};
    end else if (opcode == mct_pkg::OpAddi || opcode == mct_pkg::OpAddiu) begin
      q_op_o.kind = mct_pkg::KindAddi;
    end else if (opcode == mct_pkg::OpOri) begin
      q_op_o.kind = mct_pkg::KindOri;
      q_op_o.imm  = {16'h0000, immediate};
    end else if (insn_class == mct_pkg::ClsLoad) begin
      q_op_o.kind = mct_pkg::KindLoad;
    end else if (insn_class == mct_pkg::ClsStore) begin
      q_op_o.kind = mct_pkg::KindStore;
    end else if (opcode == mct_pkg::OpSpecial) begin
      // rd of zero: nothing happens
      q_op_o.kind = (dst_reg == '0) ? mct_pkg::KindNop : mct_pkg::KindRtype;
    end else if (insn_class == mct_pkg::ClsCall) begin
      q_op_o.kind = mct_pkg::KindCall;
    end else if (opcode >= mct_pkg::OpAddi && opcode <= mct_pkg::OpImmLast) begin
      q_op_o.kind = mct_pkg::KindForgetRt;
    end
  end

endmodule

/* design/mct_queue.sv */
// Short queue of operation words between front and back end.
// Depends on mct_pkg.
module mct_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mct_pkg::op_t  data_i,
  output logic          full_o,
  output logic          valid_o,
  output mct_pkg::op_t  data_o,
  input  logic          pop_i
);

  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  mct_pkg::op_t     mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + AddrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + AddrW'(1);
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* design/mct_back.sv */
// Back end of the MIPS constant tracker: register value RAM, known and
// valid bits, execute stage and output register. Depends on mct_pkg, mct_ram.
module mct_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          op_valid_i,
  input  mct_pkg::op_t  op_i,
  output logic          op_pop_o,
  input  logic          cfg_valid_i,
  input  logic [31:0]   cfg_data_i,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [31:0]   m_axis_tdata_o
);

  localparam int unsigned N  = mct_pkg::NumRegs;
  localparam int unsigned RW = mct_pkg::RegW;
  localparam int unsigned DW = mct_pkg::DataW;

  logic [DW-1:0]  gp_q;
  logic [DW-1:0]  gp_snap_q;
  logic [N-1:0]   known_q, known_d;
  logic [N-1:0]   valid_q, valid_d;   // entry holds a write since restart

  logic           b_valid_q;
  mct_pkg::op_t   b_op_q;
  logic           out_valid_q;
  logic [DW-1:0]  out_data_q;

  logic           fw_valid_q;
  logic [RW-1:0]  fw_addr_q;
  logic [DW-1:0]  fw_data_q;

  logic           b_adv, exec;
  logic [DW-1:0]  ram_a, ram_b;
  logic [DW-1:0]  rs_val, rt_val, sum;
  logic           wr_req, forget_req, wr_fire, forget_fire, restart;
  logic [RW-1:0]  wr_addr, forget_addr;
  logic [DW-1:0]  wr_data, res;

  assign b_adv    = !out_valid_q || m_axis_tready_i;
  assign exec     = b_valid_q && b_adv;
  assign op_pop_o = op_valid_i && (!b_valid_q || b_adv);

  mct_ram #(
    .Width (DW),
    .Depth (N)
  ) u_regs (
    .clk_i     (clk_i),
    .we_i      (exec && wr_fire),
    .waddr_i   (wr_addr),
    .wdata_i   (wr_data),
    .re_i      (op_pop_o),
    .raddr_a_i (op_i.rs),
    .raddr_b_i (op_i.rt),
    .rdata_a_o (ram_a),
    .rdata_b_o (ram_b)
  );

  function automatic logic [DW-1:0] reg_read(
    input logic [RW-1:0] addr,
    input logic [DW-1:0] ram_data,
    input logic          fw_hit,
    input logic [DW-1:0] fw_data,
    input logic          valid,
    input logic [DW-1:0] gp_snap
  );
    logic [DW-1:0] v;
    if (fw_hit) begin
      v = fw_data;
    end else if (valid) begin
      v = ram_data;
    end else if (addr == mct_pkg::GpReg) begin
      v = gp_snap;
    end else begin
      v = '0;
    end
    return v;
  endfunction

  // Forward the write made in the cycle the RAM was read
  assign rs_val = reg_read(b_op_q.rs, ram_a, fw_valid_q && (fw_addr_q == b_op_q.rs),
                           fw_data_q, valid_q[b_op_q.rs], gp_snap_q);
  assign rt_val = reg_read(b_op_q.rt, ram_b, fw_valid_q && (fw_addr_q == b_op_q.rt),
                           fw_data_q, valid_q[b_op_q.rt], gp_snap_q);
  assign sum    = rs_val + b_op_q.imm;

  always_comb begin
    wr_req      = 1'b0;
    wr_addr     = b_op_q.rt;
    wr_data     = sum;
    forget_req  = 1'b0;
    forget_addr = b_op_q.rt;
    res         = '0;
    restart     = 1'b0;
    known_d     = known_q;
    valid_d     = valid_q;
    case (b_op_q.kind)
      mct_pkg::KindRestart: begin
        restart = 1'b1;
        known_d = mct_pkg::RestartKnown;
        valid_d = '0;
      end
      mct_pkg::KindLui: begin
        wr_req  = 1'b1;
        wr_data = b_op_q.imm;
      end
      mct_pkg::KindAddi, mct_pkg::KindOri: begin
        if (b_op_q.kind == mct_pkg::KindOri) begin
          wr_data = rs_val | b_op_q.imm;
        end
        if (known_q[b_op_q.rs]) begin
          wr_req = 1'b1;
          if (b_op_q.rs != '0) begin
            res = wr_data;
          end
        end else begin
          forget_req = 1'b1;
        end
      end
      mct_pkg::KindLoad, mct_pkg::KindStore: begin
        if (known_q[b_op_q.rs]) begin
          res = sum;
        end
        forget_req = (b_op_q.kind == mct_pkg::KindLoad);
      end
      mct_pkg::KindRtype: begin
        wr_addr     = b_op_q.rd;
        forget_addr = b_op_q.rd;
        if (b_op_q.is_addu && b_op_q.rt == '0 && known_q[b_op_q.rs]) begin
          wr_req  = 1'b1;
          wr_data = rs_val;
        end else if (b_op_q.is_addu && b_op_q.rs == '0 && known_q[b_op_q.rt]) begin
          wr_req  = 1'b1;
          wr_data = rt_val;
        end else if (!b_op_q.keep_rd) begin
          forget_req = 1'b1;
        end
      end
      mct_pkg::KindCall: begin
        known_d = known_q & ~mct_pkg::CallClobber;
      end
      mct_pkg::KindForgetRt: begin
        forget_req = 1'b1;
      end
      default: begin
      end
    endcase
    // Register zero is never written
    wr_fire     = wr_req && (wr_addr != '0);
    forget_fire = forget_req && (forget_addr != '0);
    if (wr_fire) begin
      known_d[wr_addr] = 1'b1;
      valid_d[wr_addr] = 1'b1;
    end
    if (forget_fire) begin
      known_d[forget_addr] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gp_q        <= '0;
      gp_snap_q   <= '0;
      known_q     <= mct_pkg::RestartKnown;
      valid_q     <= '0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      fw_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        gp_q <= cfg_data_i;
      end
      if (op_pop_o) begin
        b_valid_q <= 1'b1;
      end else if (exec) begin
        b_valid_q <= 1'b0;
      end
      if (exec) begin
        known_q     <= known_d;
        valid_q     <= valid_d;
        out_valid_q <= 1'b1;
        if (restart) begin
          gp_snap_q  <= gp_q;
          fw_valid_q <= 1'b0;
        end else if (wr_fire) begin
          fw_valid_q <= 1'b1;
        end
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_pop_o) begin
      b_op_q <= op_i;
    end
    if (exec) begin
      out_data_q <= res;
      if (wr_fire) begin
        fw_addr_q <= wr_addr;
        fw_data_q <= wr_data;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

/* design/mips_constant_tracker.sv */
// MIPS constant tracker top level: one result per instruction item, throughput
// one item per cycle while the output is not stalled; the register-file
// read-modify-write in the back end sets it. An accepted item passes a queue entry,
// then the RAM read into the execute stage, then the output register that drives m_axis.
// Reset: tracking starts in the restart state with gp_value 0; the value RAM is
// not cleared, per-register valid bits stand in for it.
module mips_constant_tracker #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // opcode[5:0], src_reg[10:6], tgt_reg[15:11], dst_reg[20:16], func_code[26:21],
  // immediate[42:27], insn_class[45:43], zero[47:46]
  input  logic [47:0] s_axis_tdata_i,
  // action[0]
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // resolved_addr[31:0]
  output logic [31:0] m_axis_tdata_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  logic         q_full, q_push, q_valid, q_pop;
  mct_pkg::op_t q_in, q_out;

  assign cfg_ready_o = 1'b1;

  mct_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_op_o          (q_in)
  );

  mct_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .data_o  (q_out),
    .pop_i   (q_pop)
  );

  mct_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_valid_i      (q_valid),
    .op_i            (q_out),
    .op_pop_o        (q_pop),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

/* design/mct_checker.sv */
// Port-level checker for the MIPS constant tracker and its bind statement.
// Depends only on the top level's ports.
module mct_checker #(
  parameter int unsigned MaxOutstanding = 4
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o
);

  localparam int unsigned CntW = $clog2(MaxOutstanding + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            in_acc, out_acc;

  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && !out_acc) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!in_acc && out_acc) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  // Count items accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> cnt_q != '0)
    else $error("result without an outstanding item");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == CntW'(MaxOutstanding) |-> !s_axis_tready_o)
    else $error("item accepted with the pipeline full");

endmodule

bind mips_constant_tracker mct_checker #(
  .MaxOutstanding (QUEUE_DEPTH + 2)
) u_mct_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

/* tb/sv/tb_mips_constant_tracker.sv */
`timescale 1ns / 100ps
// Self-checking testbench for mips_constant_tracker: stream driver, result monitor and
// a register-tracking predictor in one top module. Depends on mct_pkg and the block.
module tb_mips_constant_tracker;

  // Opcodes and function codes that only the stimulus needs
  localparam logic [5:0] OpJal  = 6'h03;
  localparam logic [5:0] OpSlti = 6'h0A;
  localparam logic [5:0] OpLw   = 6'h23;
  localparam logic [5:0] OpSw   = 6'h2B;
  localparam logic [5:0] OpTop  = 6'h3F;
  localparam logic [5:0] FnAdd  = 6'h20;
  localparam logic [2:0] ClsOther  = 3'd0;
  localparam logic [2:0] ClsReturn = 3'd4;
  localparam logic       ActApply   = 1'b0;
  localparam logic       ActRestart = 1'b1;

  // Fields below action follow the tdata layout, lowest bit last
  typedef struct packed {
    logic       action;
    logic [2:0] cls;
    logic [15:0] imm;
    logic [5:0] fn;
    logic [4:0] rd;
    logic [4:0] rt;
    logic [4:0] rs;
    logic [5:0] opcode;
  } insn_t;

  logic        clk_i;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i  = '0;
  logic        s_axis_tuser_i  = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;
  logic        cfg_valid_i     = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i      = '0;

  mips_constant_tracker dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  insn_t       insn_q[$];
  logic [31:0] addr_expect_q[$];
  insn_t       bus_insn;
  logic        item_taken = 1'b0;
  logic        calm_q     = 1'b0;
  int unsigned error_count = 0;

  // Predicted tracking state
  logic [31:0] gp_q = '0;
  logic [31:0] reg_val [32];
  logic [31:0] reg_known;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("tb_mips_constant_tracker NOT OK");
    $finish;
  end

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic void put_reg(input logic [4:0] r, input logic k, input logic [31:0] v);
    if (r != 5'd0) begin
      reg_known[r] = k;
      reg_val[r]   = v;
    end
  endfunction

  function automatic void restart_regs();
    foreach (reg_val[i]) reg_val[i] = '0;
    reg_known               = mct_pkg::RestartKnown;
    reg_val[mct_pkg::GpReg] = gp_q;
  endfunction

  // Apply one instruction to the predicted registers, return the resolved address
  function automatic logic [31:0] track_insn(input insn_t it);
    logic [31:0] uimm;
    logic [31:0] simm;
    logic [31:0] sum;
    logic        have;
    uimm = {16'h0000, it.imm};
    simm = {{16{it.imm[15]}}, it.imm};
    sum  = '0;
    if (it.action == ActRestart) begin
      restart_regs();
      return '0;
    end
    if (it.opcode == mct_pkg::OpLui) begin
      put_reg(it.rt, 1'b1, {it.imm, 16'h0000});
      return '0;
    end
    if (it.opcode == mct_pkg::OpAddi || it.opcode == mct_pkg::OpAddiu ||
        it.opcode == mct_pkg::OpOri) begin
      have = reg_known[it.rs];
      if (have) sum = (it.opcode == mct_pkg::OpOri) ? (reg_val[it.rs] | uimm)
                                                    : (reg_val[it.rs] + simm);
      put_reg(it.rt, have, sum);
      return (have && it.rs != 5'd0) ? sum : '0;
    end
    if (it.cls == mct_pkg::ClsLoad || it.cls == mct_pkg::ClsStore) begin
      if (reg_known[it.rs]) sum = reg_val[it.rs] + simm;
      if (it.cls == mct_pkg::ClsLoad && it.rt != 5'd0) reg_known[it.rt] = 1'b0;
      return sum;
    end
    if (it.opcode == mct_pkg::OpSpecial) begin
      if (it.rd == 5'd0) return '0;
      if (it.fn == mct_pkg::FnAddu && it.rt == 5'd0 && reg_known[it.rs])
        put_reg(it.rd, 1'b1, reg_val[it.rs]);
      else if (it.fn == mct_pkg::FnAddu && it.rs == 5'd0 && reg_known[it.rt])
        put_reg(it.rd, 1'b1, reg_val[it.rt]);
      else if (it.fn != mct_pkg::FnJr && it.fn != mct_pkg::FnJalr)
        reg_known[it.rd] = 1'b0;
      return '0;
    end
    if (it.cls == mct_pkg::ClsCall) begin
      reg_known &= ~mct_pkg::CallClobber;
      return '0;
    end
    if (it.opcode >= mct_pkg::OpAddi && it.opcode <= mct_pkg::OpImmLast && it.rt != 5'd0)
      reg_known[it.rt] = 1'b0;
    return '0;
  endfunction

  function automatic insn_t insn(input logic act, input logic [5:0] op, input logic [4:0] rs,
                                 input logic [4:0] rt, input logic [4:0] rd,
                                 input logic [5:0] fn, input logic [15:0] imm,
                                 input logic [2:0] cls);
    insn_t it;
    it.action = act;
    it.opcode = op;
    it.rs     = rs;
    it.rt     = rt;
    it.rd     = rd;
    it.fn     = fn;
    it.imm    = imm;
    it.cls    = cls;
    return it;
  endfunction

  // Mostly a handful of registers so that known values chain through
  function automatic logic [4:0] hot_reg();
    logic [4:0] r;
    if ($urandom_range(3) == 0) return 5'($urandom);
    r = 5'($urandom_range(7));
    return (r == 5'd7) ? mct_pkg::GpReg : r;
  endfunction

  function automatic insn_t rand_insn();
    insn_t       it;
    int unsigned pick;
    it        = insn(ActApply, 6'($urandom), hot_reg(), hot_reg(), hot_reg(),
                     6'($urandom), 16'($urandom), 3'($urandom_range(4)));
    pick      = $urandom_range(99);
    if (pick < 3) begin
      it.action = ActRestart;
    end else if (pick < 17) begin
      it.opcode = mct_pkg::OpLui;
    end else if (pick < 38) begin
      case ($urandom_range(2))
        0:       it.opcode = mct_pkg::OpAddi;
        1:       it.opcode = mct_pkg::OpAddiu;
        default: it.opcode = mct_pkg::OpOri;
      endcase
      if ($urandom_range(1)) it.imm = 16'($urandom_range(255));
    end else if (pick < 56) begin
      it.cls    = $urandom_range(1) ? mct_pkg::ClsLoad : mct_pkg::ClsStore;
      it.opcode = (it.cls == mct_pkg::ClsLoad) ? OpLw : OpSw;
    end else if (pick < 72) begin
      it.opcode = mct_pkg::OpSpecial;
      case ($urandom_range(5))
        0, 1: begin
          it.fn = mct_pkg::FnAddu;
          it.rt = 5'd0;
        end
        2: begin
          it.fn = mct_pkg::FnAddu;
          it.rs = 5'd0;
        end
        3:       it.fn = mct_pkg::FnJr;
        4:       it.fn = mct_pkg::FnJalr;
        default: ;
      endcase
    end else if (pick < 78) begin
      it.opcode = OpJal;
      it.cls    = mct_pkg::ClsCall;
    end else if (pick < 86) begin
      it.opcode = 6'($urandom_range(mct_pkg::OpAddi, mct_pkg::OpImmLast));
      it.cls    = ClsOther;
    end else begin
      it.cls    = 3'($urandom);
      it.action = 1'($urandom_range(9) == 0);
    end
    return it;
  endfunction

  function automatic logic stall_now();
    return !calm_q && ($urandom_range(99) < 18);
  endfunction

  // Input driver: change at the falling edge, hold an item until it is taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (item_taken) begin
        item_taken = 1'b0;
        void'(insn_q.pop_front());
        if (insn_q.size() != 0 && !stall_now()) begin
          bus_insn = insn_q[0];
          s_axis_tdata_i  <= {2'b00, insn_q[0][45:0]};
          s_axis_tuser_i  <= insn_q[0].action;
          s_axis_tvalid_i <= 1'b1;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end else if (!s_axis_tvalid_i) begin
        if (insn_q.size() != 0 && !stall_now()) begin
          bus_insn = insn_q[0];
          s_axis_tdata_i  <= {2'b00, insn_q[0][45:0]};
          s_axis_tuser_i  <= insn_q[0].action;
          s_axis_tvalid_i <= 1'b1;
        end
      end
      m_axis_tready_i <= !stall_now();
    end
  end

  // Monitor: sample both handshakes at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        addr_expect_q.push_back(track_insn(bus_insn));
        item_taken = 1'b1;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (addr_expect_q.size() == 0)
          flag_error($sformatf("result %08h with no item pending", m_axis_tdata_o));
        else if (m_axis_tdata_o !== addr_expect_q[0])
          flag_error($sformatf("resolved_addr %08h, want %08h", m_axis_tdata_o,
                               addr_expect_q[0]));
        if (addr_expect_q.size() != 0) void'(addr_expect_q.pop_front());
      end
    end
  end

  task automatic drain();
    while (insn_q.size() != 0 || addr_expect_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_gp(input logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    gp_q = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_random(input logic [31:0] gp, input int unsigned count, input logic calm);
    drain();
    write_gp(gp);
    calm_q = calm;
    insn_q.push_back(insn(ActRestart, mct_pkg::OpSpecial, 5'd0, 5'd0, 5'd0, 6'd0, 16'h0000,
                          ClsOther));
    repeat (count) insn_q.push_back(rand_insn());
  endtask

  initial begin
    restart_regs();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_gp(32'h1000_8000);
    // Seed, propagate and resolve, then knock values out again
    insn_q.push_back(insn(ActRestart, mct_pkg::OpSpecial, 5'd0, 5'd0, 5'd0, 6'd0, 16'h0000,
                          ClsOther));
    insn_q.push_back(insn(ActApply, mct_pkg::OpLui, 5'd0, 5'd5, 5'd0, 6'd0, 16'h8000,
                          ClsOther));
    insn_q.push_back(insn(ActApply, mct_pkg::OpLui, 5'd0, 5'd0, 5'd0, 6'd0, 16'hFFFF,
                          ClsOther));
    insn_q.push_back(insn(ActApply, mct_pkg::OpLui, 5'd31, 5'd31, 5'd31, 6'h3F, 16'h7FFF,
                          ClsOther));
    insn_q.push_back(insn(ActApply, mct_pkg::OpAddiu, 5'd5, 5'd6, 5'd0, 6'd0, 16'hFFFF,
                          ClsOther));
    insn_q.push_back(insn(ActApply, mct_pkg::OpAddi, mct_pkg::GpReg, 5'd0, 5'd0, 6'd0,
                          16'h7FFF, ClsOther));
    insn_q.push_back(insn(ActApply, mct_pkg::OpAddi, 5'd0, 5'd7, 5'd0, 6'd0, 16'h0005,
                          ClsOther));
    insn_q.push_back(insn(ActApply, mct_pkg::OpOri, 5'd5, 5'd8, 5'd0, 6'd0, 16'hFFFF,
                          ClsOther));
    insn_q.push_back(insn(ActApply, mct_pkg::OpOri, 5'd3, 5'd9, 5'd0, 6'd0, 16'h1234,
                          ClsOther));
    insn_q.push_back(insn(ActApply, OpLw, mct_pkg::GpReg, 5'd10, 5'd0, 6'd0, 16'hFFFC,
                          mct_pkg::ClsLoad));
    insn_q.push_back(insn(ActApply, OpLw, 5'd0, 5'd0, 5'd0, 6'd0, 16'h7FFF,
                          mct_pkg::ClsLoad));
    insn_q.push_back(insn(ActApply, OpSw, 5'd3, 5'd5, 5'd0, 6'd0, 16'h0000,
                          mct_pkg::ClsStore));
    insn_q.push_back(insn(ActApply, OpSw, 5'd31, 5'd5, 5'd0, 6'd0, 16'h8000,
                          mct_pkg::ClsStore));
    insn_q.push_back(insn(ActApply, mct_pkg::OpSpecial, 5'd5, 5'd0, 5'd10, mct_pkg::FnAddu,
                          16'h0000, ClsOther));
    insn_q.push_back(insn(ActApply, mct_pkg::OpSpecial, 5'd0, 5'd6, 5'd11, mct_pkg::FnAddu,
                          16'h0000, ClsOther));
    insn_q.push_back(insn(ActApply, mct_pkg::OpSpecial, 5'd0, 5'd0, 5'd12, mct_pkg::FnAddu,
                          16'h0000, ClsOther));
    insn_q.push_back(insn(ActApply, mct_pkg::OpSpecial, 5'd5, 5'd0, 5'd0, mct_pkg::FnAddu,
                          16'h0000, ClsOther));
    insn_q.push_back(insn(ActApply, mct_pkg::OpSpecial, 5'd31, 5'd0, 5'd10, mct_pkg::FnJr,
                          16'h0000, ClsOther));
    insn_q.push_back(insn(ActApply, mct_pkg::OpSpecial, 5'd31, 5'd0, 5'd11, mct_pkg::FnJalr,
                          16'h0000, mct_pkg::ClsCall));
    insn_q.push_back(insn(ActApply, mct_pkg::OpSpecial, 5'd5, 5'd6, 5'd12, FnAdd, 16'h0000,
                          ClsOther));
    insn_q.push_back(insn(ActApply, OpSw, 5'd10, 5'd0, 5'd0, 6'd0, 16'h0010,
                          mct_pkg::ClsStore));
    insn_q.push_back(insn(ActApply, OpSw, 5'd12, 5'd0, 5'd0, 6'd0, 16'h0010,
                          mct_pkg::ClsStore));
    insn_q.push_back(insn(ActApply, OpJal, 5'd0, 5'd0, 5'd0, 6'd0, 16'h0100,
                          mct_pkg::ClsCall));
    insn_q.push_back(insn(ActApply, OpLw, 5'd5, 5'd2, 5'd0, 6'd0, 16'h0000,
                          mct_pkg::ClsLoad));
    insn_q.push_back(insn(ActApply, mct_pkg::OpAddi, mct_pkg::GpReg, 5'd2, 5'd0, 6'd0,
                          16'h0004, mct_pkg::ClsLoad));
    insn_q.push_back(insn(ActApply, OpSlti, mct_pkg::GpReg, mct_pkg::GpReg, 5'd0, 6'd0,
                          16'h0001, ClsOther));
    insn_q.push_back(insn(ActApply, mct_pkg::OpImmLast, 5'd0, 5'd31, 5'd0, 6'd0, 16'h0001,
                          ClsOther));
    insn_q.push_back(insn(ActApply, OpTop, 5'd31, 5'd31, 5'd31, 6'h3F, 16'hFFFF, ClsReturn));
    // Class codes above return fall back to class other
    insn_q.push_back(insn(ActApply, OpTop, 5'd31, 5'd31, 5'd31, 6'h3F, 16'hFFFF, 3'd7));
    insn_q.push_back(insn(ActApply, mct_pkg::OpAddiu, 5'd0, 5'd3, 5'd0, 6'd0, 16'h0040,
                          3'd5));

    run_random(32'hFFFF_FFFF, 290, 1'b0);
    run_random(32'h0000_0000, 290, 1'b0);
    run_random($urandom, 290, 1'b1);
    run_random($urandom, 290, 1'b0);
    drain();

    if (error_count == 0) begin
      $display("tb_mips_constant_tracker OK");
    end else begin
      $display("tb_mips_constant_tracker NOT OK");
    end
    $finish;
  end

endmodule
